// File: rtl/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// Used by bda_dabble and binary_to_decimal_ascii; no dependencies.
package bda_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxDigits = 20;
  localparam int DigitW    = 4;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int IdxW      = $clog2(MaxDigits);
  localparam int StepW     = $clog2(MaxWidth + 1);
  localparam int BcdW      = MaxDigits * DigitW;

  // operand width codes
  localparam logic [1:0] WCode8  = 2'd0;
  localparam logic [1:0] WCode16 = 2'd1;
  localparam logic [1:0] WCode32 = 2'd2;
  localparam logic [1:0] WCode64 = 2'd3;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiMinus = 8'h2d;

  typedef struct packed {
    logic [63:0] raw_value;
    logic [1:0]  operand_width;
    logic        is_signed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } out_item_t;

  // sequencer to conversion unit
  typedef struct packed {
    logic                load;
    logic [StepW-1:0]    steps;
    logic [MaxWidth-1:0] mag;
    logic [IdxW-1:0]     rd_idx;
  } dab_ctrl_t;

  // conversion unit to sequencer
  typedef struct packed {
    logic              done;
    logic [CntW-1:0]   digit_count;
    logic [DigitW-1:0] rd_digit;
  } dab_stat_t;

endpackage

// File: rtl/bda_dabble.sv
// Shift-and-add-3 conversion unit: one magnitude bit per cycle into BCD digits.
// Depends on bda_pkg.
module bda_dabble import bda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dab_ctrl_t ctrl_i,
  output dab_stat_t stat_o
);

  logic [MaxWidth-1:0] mag_q, mag_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [BcdW-1:0]     adj;
  logic [BcdW-1:0]     bcd_shift;
  logic [StepW-1:0]    steps_q, steps_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  // add 3 to every digit of 5 or more, then shift in the next magnitude bit
  always_comb begin
    for (int i = 0; i < MaxDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= DigitW'(5)) begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + DigitW'(3);
      end else begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
    bcd_shift = {adj[BcdW-2:0], mag_q[MaxWidth-1]};
  end

  always_comb begin
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    steps_d = steps_q;
    cnt_d   = cnt_q;
    if (ctrl_i.load) begin
      mag_d   = ctrl_i.mag;
      bcd_d   = '0;
      steps_d = ctrl_i.steps;
      cnt_d   = CntW'(1);
    end else if (steps_q != '0) begin
      mag_d   = {mag_q[MaxWidth-2:0], 1'b0};
      bcd_d   = bcd_shift;
      steps_d = steps_q - StepW'(1);
      // doubling adds at most one digit: check the next one up
      if (cnt_q < CntW'(MaxDigits) &&
          bcd_shift[cnt_q[IdxW-1:0]*DigitW +: DigitW] != '0) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      cnt_q   <= '0;
    end else begin
      steps_q <= steps_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.done        = (steps_q == '0);
  assign stat_o.digit_count = cnt_q;
  assign stat_o.rd_digit    = bcd_q[ctrl_i.rd_idx*DigitW +: DigitW];

endmodule

// File: rtl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter: sequencer, sign handling
// and character output. Depends on bda_pkg and bda_dabble.
//
//   channel  | ports                            | handshake
//   ---------+----------------------------------+-------------------------------
//   operand  | start, busy, item_i (in_item_t)  | transfer when start && !busy
//   text out | result_strobe_o, result_o        | one strobe per char, no stall
//
// Steps: the shared shift-and-add-3 unit shifts W magnitude bits (W = 8, 16, 32
// or 64 from the width code), then the sequencer sees the shift end, sends a '-'
// when negative and then one character per digit; a value has at most 20 digits,
// and a negative 64-bit value has at most 19.
// Reset: asynchronous, active low; the block comes up idle with no strobe.
// Stalls: none on the output side; busy holds off new operands until the last
// character has been sent.
module binary_to_decimal_ascii import bda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      result_strobe_o,
  output out_item_t result_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]          state_q, state_d;
  logic                neg_q, neg_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                strobe_q, strobe_d;
  out_item_t           out_q, out_d;

  logic [MaxWidth-1:0] mask;
  logic [MaxWidth-1:0] val;
  logic [MaxWidth-1:0] mag;
  logic [MaxWidth-1:0] mag_aligned;
  logic [StepW-1:0]    steps;
  logic                msb;
  logic                neg_in;
  logic                accept;

  dab_ctrl_t ctrl;
  dab_stat_t stat;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // Mask the operand to its width, take the magnitude, and left-align it so
  // the conversion unit always shifts from bit MaxWidth-1.
  always_comb begin
    mask  = '1;
    steps = StepW'(MaxWidth);
    case (item_i.operand_width)
      WCode8: begin
        mask  = MaxWidth'(8'hff);
        steps = StepW'(8);
      end
      WCode16: begin
        mask  = MaxWidth'(16'hffff);
        steps = StepW'(16);
      end
      WCode32: begin
        mask  = MaxWidth'(32'hffff_ffff);
        steps = StepW'(32);
      end
      default: begin
        mask  = '1;
        steps = StepW'(MaxWidth);
      end
    endcase
    val = item_i.raw_value & mask;
    case (item_i.operand_width)
      WCode8:  msb = val[7];
      WCode16: msb = val[15];
      WCode32: msb = val[31];
      default: msb = val[63];
    endcase
    neg_in = item_i.is_signed && msb;
    // two's complement within the operand width; the most negative value
    // stays exact as an unsigned magnitude
    mag = neg_in ? ((~val + MaxWidth'(1)) & mask) : val;
    case (item_i.operand_width)
      WCode8:  mag_aligned = mag << 56;
      WCode16: mag_aligned = mag << 48;
      WCode32: mag_aligned = mag << 32;
      default: mag_aligned = mag;
    endcase
  end

  assign ctrl.load   = accept;
  assign ctrl.steps  = steps;
  assign ctrl.mag    = mag_aligned;
  assign ctrl.rd_idx = idx_q;

  bda_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  // Sequencer: convert, then send optional sign and digits, top digit first.
  always_comb begin
    state_d  = state_q;
    neg_d    = neg_q;
    idx_d    = idx_q;
    strobe_d = 1'b0;
    out_d    = out_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          neg_d   = neg_in;
          state_d = StConv;
        end
      end
      StConv: begin
        if (stat.done) begin
          // start from the most significant held digit
          idx_d   = IdxW'(stat.digit_count - CntW'(1));
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        strobe_d         = 1'b1;
        out_d.ascii_char = AsciiMinus;
        out_d.last_char  = 1'b0;
        state_d          = StEmit;
      end
      StEmit: begin
        strobe_d         = 1'b1;
        out_d.ascii_char = AsciiZero + {4'b0000, stat.rd_digit};
        out_d.last_char  = (idx_q == '0);
        if (idx_q == '0) begin
          state_d = StIdle;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      neg_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      neg_q    <= neg_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    out_q <= out_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = out_q;

`ifndef SYNTH
  // the final character always returns the sequencer to idle
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.last_char |-> state_q == StIdle)
    else $error("last character sent while sequencer still active");

  // a minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.ascii_char == AsciiMinus |-> !result_o.last_char)
    else $error("minus sign marked as last character");

  // an accepted operand starts a conversion
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StConv && !stat.done)
    else $error("accepted operand did not start conversion");

  // the digit count stays within one and the store depth once loaded
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |->
      stat.digit_count != '0 && stat.digit_count <= CntW'(MaxDigits))
    else $error("digit count out of range");

  // no character goes out during the conversion steps
  a_quiet_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StConv && $past(state_q) == StConv |-> !result_strobe_o)
    else $error("character strobe during conversion");
`endif

endmodule
